@@ rtl/core/lbb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lbb_pkg;

  // Width of the slot index, slot select and slot count fields.
  localparam int SLOT_OUT_W = 8;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_READ  = 2'd2,
    OP_IDLE  = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_BACKGROUND = 2'd1,
    ST_UNALLOC    = 2'd2
  } status_t;

  // How the second stage forms the box of a result.
  typedef enum logic [1:0] {
    BOX_ZERO   = 2'd0,
    BOX_NEW    = 2'd1,
    BOX_UPDATE = 2'd2,
    BOX_READ   = 2'd3
  } box_mode_t;

  // Control word handed from the label stage to the box stage.
  typedef struct packed {
    logic      valid;
    status_t   status;
    box_mode_t mode;
  } stage_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/lbb_label_map.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lbb_label_map #(
  parameter int COORD_BITS = 12,
  parameter int LABEL_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire lbb_pkg::op_t                      in_op,
  input  wire logic [COORD_BITS-1:0]             in_row,
  input  wire logic [COORD_BITS-1:0]             in_col,
  input  wire logic [LABEL_BITS-1:0]             in_label,
  input  wire logic [lbb_pkg::SLOT_OUT_W-1:0]    in_sel,
  output lbb_pkg::stage_ctrl_t                   s2_ctrl_r,
  output logic [LABEL_BITS-1:0]                  s2_slot_r,
  output logic [COORD_BITS-1:0]                  s2_row_r,
  output logic [COORD_BITS-1:0]                  s2_col_r,
  output logic [lbb_pkg::SLOT_OUT_W-1:0]         s2_index_r,
  output logic [lbb_pkg::SLOT_OUT_W-1:0]         s2_count_r,
  output logic                                   box_rd_en,
  output logic [LABEL_BITS-1:0]                  box_rd_addr
);

  localparam int SlotOutW   = lbb_pkg::SLOT_OUT_W;
  localparam int LabelDepth = 2 ** LABEL_BITS;
  localparam logic [LABEL_BITS-1:0] SlotOne = LABEL_BITS'(1);

  // First stage registers, loaded on every accepted request.
  logic                    s1_valid_r;
  lbb_pkg::op_t            s1_op_r;
  logic [COORD_BITS-1:0]   s1_row_r;
  logic [COORD_BITS-1:0]   s1_col_r;
  logic [LABEL_BITS-1:0]   s1_label_r;
  logic [SlotOutW-1:0]     s1_sel_r;

  // Label state: seen flags in flops, slot numbers in a memory.
  logic [LabelDepth-1:0]   seen_r;
  logic [LabelDepth-1:0]   seen_nxt;
  logic [LABEL_BITS-1:0]   slots_used_r;
  logic [LABEL_BITS-1:0]   slots_used_nxt;
  logic [LABEL_BITS-1:0]   label_slot_mem [LabelDepth];
  logic [LABEL_BITS-1:0]   slot_q_r;
  logic                    slot_byp_hit_r;
  logic [LABEL_BITS-1:0]   slot_byp_r;

  logic                    map_wr_en;
  logic [LABEL_BITS-1:0]   known_slot;
  logic [LABEL_BITS-1:0]   alloc_count;

  lbb_pkg::stage_ctrl_t    ctrl_nxt;
  logic [LABEL_BITS-1:0]   slot_nxt;
  logic [SlotOutW-1:0]     index_nxt;
  logic [SlotOutW-1:0]     count_nxt;

  // The slot memory read was issued when the request was accepted; a slot
  // allocated by the previous request at that same edge comes from the bypass.
  assign known_slot  = slot_byp_hit_r ? slot_byp_r : slot_q_r;
  assign alloc_count = slots_used_r + SlotOne;

  // Label lookup, slot allocation and clear.
  always_comb begin
    seen_nxt       = seen_r;
    slots_used_nxt = slots_used_r;
    map_wr_en      = 1'b0;
    ctrl_nxt.valid  = s1_valid_r;
    ctrl_nxt.status = lbb_pkg::ST_DONE;
    ctrl_nxt.mode   = lbb_pkg::BOX_ZERO;
    slot_nxt       = known_slot;
    index_nxt      = '0;
    count_nxt      = SlotOutW'(slots_used_r);
    box_rd_en      = 1'b0;
    box_rd_addr    = known_slot;
    if (s1_valid_r) begin
      case (s1_op_r)
        lbb_pkg::OP_CLEAR: begin
          seen_nxt       = '0;
          slots_used_nxt = '0;
          count_nxt      = '0;
        end
        lbb_pkg::OP_PIXEL: begin
          if (s1_label_r == '0) begin
            ctrl_nxt.status = lbb_pkg::ST_BACKGROUND;
          end else if (!seen_r[s1_label_r]) begin
            seen_nxt[s1_label_r] = 1'b1;
            map_wr_en      = 1'b1;
            slots_used_nxt = alloc_count;
            slot_nxt       = slots_used_r;
            index_nxt      = SlotOutW'(slots_used_r);
            count_nxt      = SlotOutW'(alloc_count);
            ctrl_nxt.mode  = lbb_pkg::BOX_NEW;
          end else begin
            index_nxt      = SlotOutW'(known_slot);
            ctrl_nxt.mode  = lbb_pkg::BOX_UPDATE;
            box_rd_en      = 1'b1;
          end
        end
        lbb_pkg::OP_READ: begin
          index_nxt = s1_sel_r;
          if (s1_sel_r >= SlotOutW'(slots_used_r)) begin
            ctrl_nxt.status = lbb_pkg::ST_UNALLOC;
          end else begin
            ctrl_nxt.mode = lbb_pkg::BOX_READ;
            box_rd_en     = 1'b1;
            box_rd_addr   = s1_sel_r[LABEL_BITS-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      seen_r       <= '0;
      slots_used_r <= '0;
      s2_ctrl_r    <= '0;
    end else begin
      s1_valid_r   <= accept;
      seen_r       <= seen_nxt;
      slots_used_r <= slots_used_nxt;
      s2_ctrl_r    <= ctrl_nxt;
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk) begin
    s1_op_r    <= in_op;
    s1_row_r   <= in_row;
    s1_col_r   <= in_col;
    s1_label_r <= in_label;
    s1_sel_r   <= in_sel;
    s2_slot_r  <= slot_nxt;
    s2_row_r   <= s1_row_r;
    s2_col_r   <= s1_col_r;
    s2_index_r <= index_nxt;
    s2_count_r <= count_nxt;
  end

  // Label to slot memory with registered read and write-to-read bypass.
  always_ff @(posedge clk) begin
    if (map_wr_en) begin
      label_slot_mem[s1_label_r] <= slots_used_r;
    end
    slot_q_r       <= label_slot_mem[in_label];
    slot_byp_hit_r <= map_wr_en && (s1_label_r == in_label);
    slot_byp_r     <= slots_used_r;
  end

  // Every allocated slot belongs to exactly one seen label.
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones(seen_r) == slots_used_r)
    else $error("slot count differs from number of seen labels");

  // Background never gets a slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r[0])
    else $error("background label marked as seen");

  // A clear leaves an empty table behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (s1_op_r == lbb_pkg::OP_CLEAR) |=> (slots_used_r == '0) && (seen_r == '0))
    else $error("table not empty after clear");

endmodule

`default_nettype wire

@@ rtl/core/lbb_box_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lbb_box_store #(
  parameter int COORD_BITS = 12,
  parameter int LABEL_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lbb_pkg::stage_ctrl_t              s2_ctrl,
  input  wire logic [LABEL_BITS-1:0]             s2_slot,
  input  wire logic [COORD_BITS-1:0]             s2_row,
  input  wire logic [COORD_BITS-1:0]             s2_col,
  input  wire logic [lbb_pkg::SLOT_OUT_W-1:0]    s2_index,
  input  wire logic [lbb_pkg::SLOT_OUT_W-1:0]    s2_count,
  input  wire logic                              box_rd_en,
  input  wire logic [LABEL_BITS-1:0]             box_rd_addr,
  output logic                                   out_valid_r,
  output lbb_pkg::status_t                       out_status_r,
  output logic [lbb_pkg::SLOT_OUT_W-1:0]         out_slot_index_r,
  output logic                                   out_is_new_r,
  output logic [COORD_BITS-1:0]                  out_top_r,
  output logic [COORD_BITS-1:0]                  out_left_r,
  output logic [COORD_BITS-1:0]                  out_bottom_r,
  output logic [COORD_BITS-1:0]                  out_right_r,
  output logic [lbb_pkg::SLOT_OUT_W-1:0]         out_slot_count_r
);

  localparam int SlotDepth = 2 ** LABEL_BITS - 1;
  localparam int BoxW      = 4 * COORD_BITS;

  // Box memory, one word of top, left, bottom, right per slot.
  logic [BoxW-1:0]       box_mem [SlotDepth];
  logic [BoxW-1:0]       box_q_r;
  logic                  box_byp_hit_r;
  logic [BoxW-1:0]       box_byp_r;

  logic [BoxW-1:0]       cur_box;
  logic [COORD_BITS-1:0] cur_top;
  logic [COORD_BITS-1:0] cur_left;
  logic [COORD_BITS-1:0] cur_bottom;
  logic [COORD_BITS-1:0] cur_right;
  logic [BoxW-1:0]       box_nxt;
  logic                  box_wr_en;

  // The previous pixel wrote at the edge this read was taken: use its box.
  assign cur_box = box_byp_hit_r ? box_byp_r : box_q_r;
  assign {cur_top, cur_left, cur_bottom, cur_right} = cur_box;

  // New box, widened box, stored box or zero.
  always_comb begin
    box_nxt   = '0;
    box_wr_en = 1'b0;
    case (s2_ctrl.mode)
      lbb_pkg::BOX_NEW: begin
        box_nxt   = {s2_row, s2_col, s2_row, s2_col};
        box_wr_en = s2_ctrl.valid;
      end
      lbb_pkg::BOX_UPDATE: begin
        box_nxt   = {(s2_row < cur_top)    ? s2_row : cur_top,
                     (s2_col < cur_left)   ? s2_col : cur_left,
                     (s2_row > cur_bottom) ? s2_row : cur_bottom,
                     (s2_col > cur_right)  ? s2_col : cur_right};
        box_wr_en = s2_ctrl.valid;
      end
      lbb_pkg::BOX_READ: begin
        box_nxt = cur_box;
      end
      default: begin
        box_nxt = '0;
      end
    endcase
  end

  // Box memory write, registered read and bypass capture.
  always_ff @(posedge clk) begin
    if (box_wr_en) begin
      box_mem[s2_slot] <= box_nxt;
    end
    if (box_rd_en) begin
      box_q_r <= box_mem[box_rd_addr];
    end
    box_byp_hit_r <= box_wr_en && box_rd_en && (s2_slot == box_rd_addr);
    box_byp_r     <= box_nxt;
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_ctrl.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_status_r     <= s2_ctrl.status;
    out_slot_index_r <= s2_index;
    out_is_new_r     <= (s2_ctrl.mode == lbb_pkg::BOX_NEW);
    out_top_r        <= box_nxt[BoxW-1 -: COORD_BITS];
    out_left_r       <= box_nxt[3*COORD_BITS-1 -: COORD_BITS];
    out_bottom_r     <= box_nxt[2*COORD_BITS-1 -: COORD_BITS];
    out_right_r      <= box_nxt[COORD_BITS-1:0];
    out_slot_count_r <= s2_count;
  end

  // A newly allocated slot is the last one counted.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_new_r |->
      (out_slot_count_r == out_slot_index_r + 8'd1) && (out_status_r == lbb_pkg::ST_DONE))
    else $error("new slot does not match slot count");

  // Every box that is reported is well ordered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_top_r <= out_bottom_r) && (out_left_r <= out_right_r))
    else $error("box bounds out of order");

  // A read of an unallocated slot carries no box.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == lbb_pkg::ST_UNALLOC) |->
      !out_is_new_r && (out_top_r == '0) && (out_right_r == '0))
    else $error("unallocated read reports a box");

endmodule

`default_nettype wire

@@ rtl/core/label_bounding_box_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+------------------------------
// request  | in_operation, in_pixel_row, in_pixel_col,      | taken when start && !busy
//          | in_pixel_label, in_slot_select                 |
// result   | out_status, out_slot_index, out_slot_is_new,   | out_valid for one cycle,
//          | out_box_top/left/bottom/right, out_slot_count  | always taken
//
// One request is taken every cycle while not busy; each gives exactly one result.
// The throughput is set by the single read-modify-write of the slot box memory per request,
// with bypass registers covering back-to-back hits on the same label or slot.
// Reset is synchronous and active low; busy is high in the cycle after reset and low after.
// No clearing pass is needed: label flags are flops that a clear request resets together.
// The receiver cannot stall results, so the pipeline never holds.

module label_bounding_box_table_core #(
  parameter int COORD_BITS = 12,
  parameter int LABEL_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_operation,
  input  wire logic [COORD_BITS-1:0]          in_pixel_row,
  input  wire logic [COORD_BITS-1:0]          in_pixel_col,
  input  wire logic [LABEL_BITS-1:0]          in_pixel_label,
  input  wire logic [lbb_pkg::SLOT_OUT_W-1:0] in_slot_select,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [lbb_pkg::SLOT_OUT_W-1:0]      out_slot_index,
  output logic                                out_slot_is_new,
  output logic [COORD_BITS-1:0]               out_box_top,
  output logic [COORD_BITS-1:0]               out_box_left,
  output logic [COORD_BITS-1:0]               out_box_bottom,
  output logic [COORD_BITS-1:0]               out_box_right,
  output logic [lbb_pkg::SLOT_OUT_W-1:0]      out_slot_count
);

  logic                                busy_r;
  logic                                accept;
  lbb_pkg::stage_ctrl_t                s2_ctrl;
  logic [LABEL_BITS-1:0]               s2_slot;
  logic [COORD_BITS-1:0]               s2_row;
  logic [COORD_BITS-1:0]               s2_col;
  logic [lbb_pkg::SLOT_OUT_W-1:0]      s2_index;
  logic [lbb_pkg::SLOT_OUT_W-1:0]      s2_count;
  logic                                box_rd_en;
  logic [LABEL_BITS-1:0]               box_rd_addr;
  lbb_pkg::status_t                    out_status_e;

  // Busy only while coming out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Label lookup and slot allocation.
  lbb_label_map #(
    .COORD_BITS (COORD_BITS),
    .LABEL_BITS (LABEL_BITS)
  ) u_label_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_op       (lbb_pkg::op_t'(in_operation)),
    .in_row      (in_pixel_row),
    .in_col      (in_pixel_col),
    .in_label    (in_pixel_label),
    .in_sel      (in_slot_select),
    .s2_ctrl_r   (s2_ctrl),
    .s2_slot_r   (s2_slot),
    .s2_row_r    (s2_row),
    .s2_col_r    (s2_col),
    .s2_index_r  (s2_index),
    .s2_count_r  (s2_count),
    .box_rd_en   (box_rd_en),
    .box_rd_addr (box_rd_addr)
  );

  // Box read-modify-write and result register.
  lbb_box_store #(
    .COORD_BITS (COORD_BITS),
    .LABEL_BITS (LABEL_BITS)
  ) u_box_store (
    .clk              (clk),
    .rst_n            (rst_n),
    .s2_ctrl          (s2_ctrl),
    .s2_slot          (s2_slot),
    .s2_row           (s2_row),
    .s2_col           (s2_col),
    .s2_index         (s2_index),
    .s2_count         (s2_count),
    .box_rd_en        (box_rd_en),
    .box_rd_addr      (box_rd_addr),
    .out_valid_r      (out_valid),
    .out_status_r     (out_status_e),
    .out_slot_index_r (out_slot_index),
    .out_is_new_r     (out_slot_is_new),
    .out_top_r        (out_box_top),
    .out_left_r       (out_box_left),
    .out_bottom_r     (out_box_bottom),
    .out_right_r      (out_box_right),
    .out_slot_count_r (out_slot_count)
  );

  assign out_status = out_status_e;

endmodule

`default_nettype wire

@@ tb/sv/tb_label_bounding_box_table_core.sv @@
`timescale 1ns / 1ps

module tb_label_bounding_box_table_core;

  localparam int COORD_W = 12;
  localparam int LABEL_W = 8;
  localparam int SLOT_W = lbb_pkg::SLOT_OUT_W;
  localparam int NUM_SLOTS = 255;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int RANDOM_ITEMS = 1550;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;

  // One request as it is presented on the input ports.
  typedef struct {
    lbb_pkg::op_t       op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [LABEL_W-1:0] label;
    logic [SLOT_W-1:0]  sel;
  } box_req_t;

  // One result as it appears on the output ports.
  typedef struct {
    lbb_pkg::status_t   status;
    logic [SLOT_W-1:0]  slot;
    logic               is_new;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [SLOT_W-1:0]  count;
  } box_res_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_operation;
  logic [COORD_W-1:0]  in_pixel_row;
  logic [COORD_W-1:0]  in_pixel_col;
  logic [LABEL_W-1:0]  in_pixel_label;
  logic [SLOT_W-1:0]   in_slot_select;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [SLOT_W-1:0]   out_slot_index;
  logic                out_slot_is_new;
  logic [COORD_W-1:0]  out_box_top;
  logic [COORD_W-1:0]  out_box_left;
  logic [COORD_W-1:0]  out_box_bottom;
  logic [COORD_W-1:0]  out_box_right;
  logic [SLOT_W-1:0]   out_slot_count;

  // Requests waiting for the driver, and results the table still owes us.
  box_req_t request_q[$];
  box_res_t box_results_q[$];

  // Shadow copy of the label table and the slot boxes.
  bit                 label_seen [0:255];
  logic [SLOT_W-1:0]  label_slot [0:255];
  logic [COORD_W-1:0] box_top [0:NUM_SLOTS-1];
  logic [COORD_W-1:0] box_left [0:NUM_SLOTS-1];
  logic [COORD_W-1:0] box_bottom [0:NUM_SLOTS-1];
  logic [COORD_W-1:0] box_right [0:NUM_SLOTS-1];
  int                 slots_used;

  int mismatch_count;
  int accepted_count;
  int stall_cycles;
  bit req_taken;

  label_bounding_box_table_core #(
    .COORD_BITS(COORD_W),
    .LABEL_BITS(LABEL_W)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_pixel_row   (in_pixel_row),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_label (in_pixel_label),
    .in_slot_select (in_slot_select),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_slot_is_new(out_slot_is_new),
    .out_box_top    (out_box_top),
    .out_box_left   (out_box_left),
    .out_box_bottom (out_box_bottom),
    .out_box_right  (out_box_right),
    .out_slot_count (out_slot_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one request to the shadow table and return the result it should give.
  function automatic box_res_t track_label_box(box_req_t r);
    box_res_t           res;
    logic [SLOT_W-1:0]  s;
    res.status = lbb_pkg::ST_DONE;
    res.slot = '0;
    res.is_new = 1'b0;
    res.top = '0;
    res.left = '0;
    res.bottom = '0;
    res.right = '0;
    case (r.op)
      lbb_pkg::OP_CLEAR: begin
        foreach (label_seen[i]) label_seen[i] = 1'b0;
        slots_used = 0;
      end
      lbb_pkg::OP_PIXEL: begin
        if (r.label == '0) begin
          res.status = lbb_pkg::ST_BACKGROUND;
        end else begin
          if (!label_seen[r.label]) begin
            // First pixel of this label in the frame takes the next slot.
            s = SLOT_W'(slots_used);
            label_seen[r.label] = 1'b1;
            label_slot[r.label] = s;
            box_top[s] = r.row;
            box_left[s] = r.col;
            box_bottom[s] = r.row;
            box_right[s] = r.col;
            slots_used++;
            res.is_new = 1'b1;
          end else begin
            s = label_slot[r.label];
            if (r.row < box_top[s]) box_top[s] = r.row;
            if (r.row > box_bottom[s]) box_bottom[s] = r.row;
            if (r.col < box_left[s]) box_left[s] = r.col;
            if (r.col > box_right[s]) box_right[s] = r.col;
          end
          res.slot = s;
          res.top = box_top[s];
          res.left = box_left[s];
          res.bottom = box_bottom[s];
          res.right = box_right[s];
        end
      end
      lbb_pkg::OP_READ: begin
        res.slot = r.sel;
        if (int'(r.sel) >= slots_used) begin
          res.status = lbb_pkg::ST_UNALLOC;
        end else begin
          res.top = box_top[r.sel];
          res.left = box_left[r.sel];
          res.bottom = box_bottom[r.sel];
          res.right = box_right[r.sel];
        end
      end
      default: begin
      end
    endcase
    res.count = SLOT_W'(slots_used);
    return res;
  endfunction

  // Print one line per mismatch and keep count.
  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Queue a request; fields that the operation ignores carry random values.
  task automatic push_request(lbb_pkg::op_t op, int row, int col, int label, int sel);
    box_req_t r;
    r.op = op;
    r.row = COORD_W'(row);
    r.col = COORD_W'(col);
    r.label = LABEL_W'(label);
    r.sel = SLOT_W'(sel);
    request_q.insert(request_q.size(), r);
  endtask

  task automatic push_pixel(int row, int col, int label);
    push_request(lbb_pkg::OP_PIXEL, row, col, label, $urandom);
  endtask

  task automatic push_read(int sel);
    push_request(lbb_pkg::OP_READ, $urandom, $urandom, $urandom, sel);
  endtask

  task automatic push_other(lbb_pkg::op_t op);
    push_request(op, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Coordinates lean toward the edges now and then.
  function automatic int rand_coord();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return 0;
    if (pick < 12) return COORD_MAX;
    return $urandom_range(0, COORD_MAX);
  endfunction

  // Driver: present the next request once the previous one has been taken.
  always @(negedge clk) begin : drive_requests
    box_req_t r;
    bit       quiet;
    bit       hold_off;
    quiet = (accepted_count >= 500) && (accepted_count < 800);
    hold_off = !quiet && ($urandom_range(0, 99) < 9);
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (request_q.size() != 0 && !hold_off) begin
        r = request_q.pop_front();
        start <= 1'b1;
        in_operation <= r.op;
        in_pixel_row <= r.row;
        in_pixel_col <= r.col;
        in_pixel_label <= r.label;
        in_slot_select <= r.sel;
      end else begin
        start <= 1'b0;
        in_operation <= 2'($urandom);
        in_pixel_row <= COORD_W'($urandom);
        in_pixel_col <= COORD_W'($urandom);
        in_pixel_label <= LABEL_W'($urandom);
        in_slot_select <= SLOT_W'($urandom);
      end
    end
  end

  // Monitor: check each result, predict each accepted request, watch for a hang.
  always @(posedge clk) begin : watch_ports
    box_req_t r;
    box_res_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (box_results_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = box_results_q.pop_front();
          check_field("status", COORD_W'(out_status), COORD_W'(want.status));
          check_field("slot_index", COORD_W'(out_slot_index), COORD_W'(want.slot));
          check_field("slot_is_new", COORD_W'(out_slot_is_new), COORD_W'(want.is_new));
          check_field("box_top", out_box_top, want.top);
          check_field("box_left", out_box_left, want.left);
          check_field("box_bottom", out_box_bottom, want.bottom);
          check_field("box_right", out_box_right, want.right);
          check_field("slot_count", COORD_W'(out_slot_count), COORD_W'(want.count));
        end
      end
      req_taken = (start === 1'b1) && (busy === 1'b0);
      if (req_taken) begin
        r.op = lbb_pkg::op_t'(in_operation);
        r.row = in_pixel_row;
        r.col = in_pixel_col;
        r.label = in_pixel_label;
        r.sel = in_slot_select;
        box_results_q.insert(box_results_q.size(), track_label_box(r));
        accepted_count++;
      end
      if (req_taken || out_valid === 1'b1)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[label_bounding_box_table_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int         total_items;
    int         pool_n;
    int         frame_len;
    int         pick;
    logic [7:0] pool [0:63];

    rst_n = 1'b0;
    start = 1'b0;
    in_operation = '0;
    in_pixel_row = '0;
    in_pixel_col = '0;
    in_pixel_label = '0;
    in_slot_select = '0;
    mismatch_count = 0;
    accepted_count = 0;
    stall_cycles = 0;
    req_taken = 1'b0;
    slots_used = 0;
    foreach (label_seen[i]) label_seen[i] = 1'b0;

    // Directed requests: empty table, edges of the coordinate range, background,
    // unallocated reads, the unused operation, back-to-back hits and a clear.
    push_read(0);
    push_pixel(0, 0, 0);
    push_pixel(COORD_MAX, COORD_MAX, 255);
    push_pixel(0, 0, 255);
    push_pixel(2048, 100, 255);
    push_pixel(0, COORD_MAX, 1);
    push_pixel(COORD_MAX, 0, 1);
    push_read(0);
    push_read(1);
    push_read(2);
    push_read(255);
    push_read(254);
    push_other(lbb_pkg::OP_IDLE);
    push_pixel(COORD_MAX, COORD_MAX, 0);
    push_pixel(100, 200, 128);
    push_pixel(100, 200, 128);
    push_pixel(99, 201, 128);
    push_read(2);
    push_other(lbb_pkg::OP_CLEAR);
    push_read(0);
    push_pixel(5, 6, 255);
    push_read(0);

    // One frame that uses every nonzero label, so all slots get allocated.
    push_other(lbb_pkg::OP_CLEAR);
    for (int lab = 1; lab < 256; lab++)
      push_pixel(rand_coord(), rand_coord(), lab);
    for (int i = 0; i < 20; i++)
      push_pixel(rand_coord(), rand_coord(), $urandom_range(0, 255));
    push_read(254);
    push_read(255);
    push_read(0);
    push_read($urandom_range(0, 255));

    // Random frames: mostly a clear followed by pixels from a small set of labels,
    // with reads mixed in and a little noise.
    while (request_q.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) != 0)
        push_other(lbb_pkg::OP_CLEAR);
      pool_n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      for (int i = 0; i < pool_n; i++)
        pool[i] = 8'($urandom_range(1, 255));
      frame_len = $urandom_range(10, 80);
      for (int i = 0; i < frame_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 68)
          push_pixel(rand_coord(), rand_coord(), pool[$urandom_range(0, pool_n - 1)]);
        else if (pick < 74)
          push_pixel(rand_coord(), rand_coord(), 0);
        else if (pick < 88)
          push_read($urandom_range(0, pool_n + 1));
        else if (pick < 92)
          push_read($urandom_range(0, 255));
        else if (pick < 96)
          push_other(lbb_pkg::OP_IDLE);
        else
          push_pixel($urandom, $urandom, $urandom_range(0, 255));
      end
    end
    total_items = request_q.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted_count < total_items) @(posedge clk);
    while (box_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[label_bounding_box_table_core] OK");
    else
      $display("[label_bounding_box_table_core] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lbb_pkg.sv
rtl/core/lbb_label_map.sv
rtl/core/lbb_box_store.sv
rtl/core/label_bounding_box_table_core.sv
tb/sv/tb_label_bounding_box_table_core.sv
